// File: src/a2d_pkg.sv
package a2d_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int OP_W      = 3;
    localparam int MAT_N     = 6;
    localparam int ROW_N     = 3;

    // exact product plus rounding headroom, and a sum of up to three terms
    localparam int PROD_W = 2 * Q_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_q [MAT_N-1:0]           t_mat;

    typedef enum logic [OP_W-1:0] {
        OP_IDENTITY  = 3'd0,
        OP_TRANSLATE = 3'd1,
        OP_SCALE     = 3'd2,
        OP_ROTATE    = 3'd3,
        OP_POINT     = 3'd4
    } t_op;

    localparam t_q    Q_ONE   = t_q'(1) << FRAC_BITS;
    localparam t_q    Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q    Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
    localparam t_prod P_ROUND = t_prod'(1) << (FRAC_BITS - 1);

    // matrix entry order m00 m01 m02 m10 m11 m12
    localparam t_mat MAT_IDENTITY = {t_q'(0), Q_ONE, t_q'(0), t_q'(0), t_q'(0), Q_ONE};

    // sign extend one value to the sum width
    function automatic t_sum sext_sum(input t_q v);
        return t_sum'(v);
    endfunction

    // rounded Q product, half toward plus infinity
    function automatic t_sum qmul(input t_q a, input t_q b);
        t_prod p;
        t_prod r;
        p = t_prod'(a) * t_prod'(b);
        r = (p + P_ROUND) >>> FRAC_BITS;
        return t_sum'(r);
    endfunction

    // clamp to the signed 32-bit range
    function automatic t_q sat(input t_sum v);
        t_q res;
        if (v > t_sum'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < t_sum'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/affine_2d_transform_unit.sv
// 2D affine transform unit, top two rows of a 3x3 homogeneous matrix in Q16.16.
// Command channel (s_axis): tuser carries the operation (identity, translate,
// scale, rotate, transform point), tdata carries operand_a and operand_b.
// Result channel (m_axis): one word per transform-point command, holding
// out_x and out_y; matrix commands produce no word.
// Throughput is one command per cycle unless a point is held (see below): a
// command sits in the input register, where twelve parallel rounded multiplies
// and the saturating adds update the matrix register as the command leaves it,
// so the next command already sees the new matrix.
// A point passes from the input register to the result register, which drives m_axis.
// Reset loads the identity matrix and empties both registers.
// When the receiver stalls, matrix commands keep flowing; a point that reaches
// the input register while the result register is full holds there and
// s_axis_tready drops until the waiting result is taken.
module affine_2d_transform_unit
    import a2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [2*Q_W-1:0]  i_s_axis_tdata,  // operand_a, operand_b
    input  logic [OP_W-1:0]   i_s_axis_tuser,  // operation
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [2*Q_W-1:0]  o_m_axis_tdata   // out_x, out_y
);

    logic r_in_valid;
    t_op  r_op;
    t_q   r_a;
    t_q   r_b;
    t_mat r_mat;
    t_mat n_mat;
    logic r_out_valid;
    t_q   r_out_x;
    t_q   r_out_y;
    t_q   n_x;
    t_q   n_y;
    logic in_point;
    logic out_free;
    logic advance;

    // handshake control
    assign in_point        = r_in_valid && (r_op == OP_POINT);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = !r_in_valid || !in_point || out_free;
    assign o_s_axis_tready = advance;

    a2d_datapath u_datapath (
        .i_op  (r_op),
        .i_a   (r_a),
        .i_b   (r_b),
        .i_mat (r_mat),
        .o_mat (n_mat),
        .o_x   (n_x),
        .o_y   (n_y)
    );

    // control and matrix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mat       <= MAT_IDENTITY;
        end else begin
            if (advance) begin
                r_in_valid <= i_s_axis_tvalid;
                if (r_in_valid) begin
                    r_mat <= n_mat;
                end
            end
            if (in_point && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (advance && i_s_axis_tvalid) begin
            r_op <= t_op'(i_s_axis_tuser);
            r_a  <= i_s_axis_tdata[Q_W-1:0];
            r_b  <= i_s_axis_tdata[2*Q_W-1:Q_W];
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (in_point && out_free) begin
            r_out_x <= n_x;
            r_out_y <= n_y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};

`ifndef NO_ASSERTIONS
    // a point never leaves the input register into a full, stalled result register
    a_point_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_point && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("point accepted over a stalled result");

    // a result word only appears after a point was processed
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_point))
        else $error("result word without a point command");

    // identity command always restores the identity matrix
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_op == OP_IDENTITY)) |=> (r_mat == MAT_IDENTITY))
        else $error("identity command did not load identity");

    // matrix holds when no command is in the input register
    a_mat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_mat))
        else $error("matrix changed with no command");
`endif

endmodule

// File: src/a2d_datapath.sv
module a2d_datapath
    import a2d_pkg::*;
(
    input  t_op  i_op,
    input  t_q   i_a,
    input  t_q   i_b,
    input  t_mat i_mat,
    output t_mat o_mat,
    output t_q   o_x,
    output t_q   o_y
);

    t_sum pa [MAT_N];
    t_sum pb [MAT_N];

    // twelve independent rounded products against the current matrix
    always_comb begin
        for (int j = 0; j < MAT_N; j++) begin
            pa[j] = qmul(i_a, i_mat[j]);
            pb[j] = qmul(i_b, i_mat[j]);
        end
    end

    // next matrix
    always_comb begin
        o_mat = i_mat;
        case (i_op)
            OP_IDENTITY: begin
                o_mat = MAT_IDENTITY;
            end
            OP_TRANSLATE: begin
                o_mat[2] = sat(sext_sum(i_mat[2]) + sext_sum(i_a));
                o_mat[5] = sat(sext_sum(i_mat[5]) + sext_sum(i_b));
            end
            OP_SCALE: begin
                for (int j = 0; j < ROW_N; j++) begin
                    o_mat[j]         = sat(pa[j]);
                    o_mat[ROW_N + j] = sat(pb[ROW_N + j]);
                end
            end
            OP_ROTATE: begin
                for (int j = 0; j < ROW_N; j++) begin
                    o_mat[j]         = sat(pa[j] - pb[ROW_N + j]);
                    o_mat[ROW_N + j] = sat(pb[j] + pa[ROW_N + j]);
                end
            end
            default: begin
                o_mat = i_mat;
            end
        endcase
    end

    // transformed point
    assign o_x = sat(pa[0] + pb[1] + sext_sum(i_mat[2]));
    assign o_y = sat(pa[3] + pb[4] + sext_sum(i_mat[5]));

endmodule

// File: tb/tb_affine_2d_transform_unit.sv
module tb_affine_2d_transform_unit;
    import a2d_pkg::*;

    // unused operation codes, the block must ignore them
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [OP_W-1:0] op;
        t_q              a;
        t_q              b;
    } xform_cmd_t;

    typedef struct {
        t_q x;
        t_q y;
    } point_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [2*Q_W-1:0] s_data = '0;
    logic [OP_W-1:0]  s_user = '0;
    logic             m_ready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [2*Q_W-1:0] o_m_axis_tdata;

    xform_cmd_t cmd_q[$];
    point_t     point_q[$];
    t_q         xform_mat [MAT_N] = '{Q_ONE, 0, 0, 0, Q_ONE, 0};
    logic       cmd_fire = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_req = 0;
    int         hold_cnt = 0;
    int         cmd_cnt = 0;
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;

    affine_2d_transform_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // operand_a, operand_b
        .i_s_axis_tuser  (s_user),   // operation
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)  // out_x, out_y
    );

    // clock and reset
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // rounded q product, half toward plus infinity
    function automatic longint q_product(input t_q a, input t_q b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic t_q clamp_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return t_q'(v);
    endfunction

    // apply one command to the matrix, return a point when one is produced
    task automatic apply_command(input xform_cmd_t c, output bit has_pt, output point_t pt);
        t_q prev [MAT_N];
        prev = xform_mat;
        has_pt = 1'b0;
        pt = '{0, 0};
        case (c.op)
            OP_IDENTITY: begin
                xform_mat = '{Q_ONE, 0, 0, 0, Q_ONE, 0};
            end
            OP_TRANSLATE: begin
                xform_mat[2] = clamp_q(longint'(prev[2]) + longint'(c.a));
                xform_mat[5] = clamp_q(longint'(prev[5]) + longint'(c.b));
            end
            OP_SCALE: begin
                for (int j = 0; j < ROW_N; j++) begin
                    xform_mat[j] = clamp_q(q_product(c.a, prev[j]));
                    xform_mat[ROW_N+j] = clamp_q(q_product(c.b, prev[ROW_N+j]));
                end
            end
            OP_ROTATE: begin
                for (int j = 0; j < ROW_N; j++) begin
                    xform_mat[j] = clamp_q(q_product(c.a, prev[j])
                                           - q_product(c.b, prev[ROW_N+j]));
                    xform_mat[ROW_N+j] = clamp_q(q_product(c.b, prev[j])
                                                 + q_product(c.a, prev[ROW_N+j]));
                end
            end
            OP_POINT: begin
                has_pt = 1'b1;
                pt.x = clamp_q(q_product(prev[0], c.a) + q_product(prev[1], c.b)
                               + longint'(prev[2]));
                pt.y = clamp_q(q_product(prev[3], c.a) + q_product(prev[4], c.b)
                               + longint'(prev[5]));
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    // output check, then prediction of the accepted command word
    always @(posedge i_clk) begin
        xform_cmd_t c;
        point_t     want;
        point_t     got;
        bit         has_pt;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                got.x = o_m_axis_tdata[Q_W-1:0];
                got.y = o_m_axis_tdata[2*Q_W-1:Q_W];
                if (point_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word x=%h y=%h", got.x, got.y));
                end else begin
                    want = point_q.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("out_x %h, want %h", got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("out_y %h, want %h", got.y, want.y));
                end
            end
            if (s_valid && o_s_axis_tready) begin
                c.op = s_user;
                c.a = s_data[Q_W-1:0];
                c.b = s_data[2*Q_W-1:Q_W];
                apply_command(c, has_pt, want);
                if (has_pt) point_q.push_back(want);
            end
        end
        cmd_fire <= i_rst_n && s_valid && o_s_axis_tready;
    end

    // command driver, holds a word until it is taken
    always @(negedge i_clk) begin
        xform_cmd_t c;
        if (i_rst_n && (!s_valid || cmd_fire)) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                c = cmd_q.pop_front();
                s_valid <= 1'b1;
                s_user <= c.op;
                s_data <= {c.b, c.a};
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input t_q a, input t_q b);
        cmd_q.push_back('{op, a, b});
        if (op <= OP_POINT) cmd_cnt++;
    endtask

    function automatic t_q rand_span(input int unsigned span);
        return t_q'($urandom_range(0, 2 * span) - span);
    endfunction

    // mostly well formed: reset, a few matrix ops, then a burst of points
    task automatic push_random_sequence();
        logic [OP_W-1:0] op;
        bit              wide;
        if ($urandom_range(0, 99) < 15) begin
            push_cmd(OP_W'($urandom_range(0, 7)), t_q'($urandom()), t_q'($urandom()));
        end else begin
            if ($urandom_range(0, 3) != 0)
                push_cmd(OP_IDENTITY, t_q'($urandom()), t_q'($urandom()));
            repeat ($urandom_range(0, 4)) begin
                op = OP_W'($urandom_range(OP_TRANSLATE, OP_ROTATE));
                wide = ($urandom_range(0, 9) == 0);
                if (wide)
                    push_cmd(op, t_q'($urandom()), t_q'($urandom()));
                else if (op == OP_TRANSLATE)
                    push_cmd(op, rand_span(1 << 26), rand_span(1 << 26));
                else
                    push_cmd(op, rand_span(1 << 17), rand_span(1 << 17));
            end
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(OP_POINT, t_q'($urandom()), t_q'($urandom()));
                else
                    push_cmd(OP_POINT, rand_span(1 << 26), rand_span(1 << 26));
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_valid || point_q.size() != 0) @(posedge i_clk);
    endtask

    // stimulus phases
    initial begin
        send_idle_pct = 32;
        recv_idle_pct = 72;
        wait (i_rst_n);

        // points through identity, extremes included
        push_cmd(OP_POINT, Q_ONE, -Q_ONE);
        push_cmd(OP_POINT, Q_MAX, Q_MIN);
        push_cmd(OP_POINT, Q_MIN, Q_MAX);
        // translate saturates at both ends
        push_cmd(OP_TRANSLATE, Q_MAX, Q_MIN);
        push_cmd(OP_TRANSLATE, Q_MAX, Q_MIN);
        push_cmd(OP_POINT, Q_MAX, Q_MAX);
        push_cmd(OP_POINT, Q_MIN, Q_MIN);
        // identity ignores its operands
        push_cmd(OP_IDENTITY, Q_MAX, Q_MIN);
        push_cmd(OP_SCALE, Q_MAX, Q_MIN);
        push_cmd(OP_POINT, Q_ONE, Q_ONE);
        push_cmd(OP_SCALE, Q_MIN, Q_MAX);
        push_cmd(OP_POINT, -Q_ONE, Q_MAX);
        push_cmd(OP_IDENTITY, '1, '1);
        // quarter turn and thirty degrees
        push_cmd(OP_ROTATE, t_q'(0), Q_ONE);
        push_cmd(OP_POINT, Q_ONE, t_q'(2) <<< FRAC_BITS);
        push_cmd(OP_ROTATE, t_q'(56756), t_q'(32768));
        push_cmd(OP_TRANSLATE, t_q'(10) <<< FRAC_BITS, -(t_q'(3) <<< FRAC_BITS));
        push_cmd(OP_POINT, t_q'(1), -t_q'(1));
        // rotation pair far from unit length
        push_cmd(OP_ROTATE, Q_MAX, Q_MIN);
        push_cmd(OP_POINT, Q_ONE, Q_ONE);
        // spare codes leave the matrix alone
        push_cmd(OP_SPARE_5, t_q'($urandom()), t_q'($urandom()));
        push_cmd(OP_SPARE_6, t_q'($urandom()), t_q'($urandom()));
        push_cmd(OP_SPARE_7, t_q'($urandom()), t_q'($urandom()));
        push_cmd(OP_POINT, t_q'(32768), -t_q'(32768));
        push_cmd(OP_IDENTITY, '0, '0);

        while (cmd_cnt < 280) push_random_sequence();
        wait_drained();

        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = HOLD_CYCLES;
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                push_cmd(OP_W'($urandom_range(OP_IDENTITY, OP_ROTATE)),
                         rand_span(1 << 17), rand_span(1 << 17));
            else
                push_cmd(OP_POINT, rand_span(1 << 26), rand_span(1 << 26));
        end
        wait_drained();

        send_idle_pct = 72;
        recv_idle_pct = 32;
        while (cmd_cnt < 600) push_random_sequence();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (cmd_cnt < 850) push_random_sequence();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (point_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", point_q.size()));
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/a2d_pkg.sv
src/a2d_datapath.sv
src/affine_2d_transform_unit.sv
tb/tb_affine_2d_transform_unit.sv
